FILE: sv/itda_pkg.sv
// Shared constants and types for the integer to decimal ASCII unit.
package itda_pkg;

    localparam int VALUE_W        = 32;
    localparam int CHAR_W         = 6;
    localparam int DIGIT_W        = 4;
    localparam int NUM_DIGITS     = 10;
    localparam int BCD_W          = NUM_DIGITS * DIGIT_W;
    localparam int POS_W          = 4;
    localparam int NUM_STAGES     = 4;
    localparam int BITS_PER_STAGE = VALUE_W / NUM_STAGES;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    // Conversion word carried down the pipeline
    typedef struct packed {
        logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd;
        logic [VALUE_W-1:0]                 bin;
        logic                               neg;
    } itda_conv_t;

endpackage

FILE: sv/itda_dabble_stage.sv
// One register stage of the shift-and-add-3 binary to BCD converter.
module itda_dabble_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  itda_pkg::itda_conv_t in_data,
    output logic                 out_valid,
    output itda_pkg::itda_conv_t out_data
);
    import itda_pkg::*;

    logic       valid_reg;
    itda_conv_t data_reg;
    itda_conv_t data_next;

    // One double-dabble iteration: correct digits of five or more, shift in a bit
    function automatic itda_conv_t dabble_step(input itda_conv_t d);
        itda_conv_t r;
        logic [NUM_DIGITS-1:0][DIGIT_W-1:0] corr;
        logic [BCD_W-1:0]                   flat;
        r = d;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            corr[i] = (d.bcd[i] >= 4'd5) ? d.bcd[i] + 4'd3 : d.bcd[i];
        end
        flat  = corr;
        r.bcd = {flat[BCD_W-2:0], d.bin[VALUE_W-1]};
        r.bin = {d.bin[VALUE_W-2:0], 1'b0};
        return r;
    endfunction

    // Bits handled by this stage
    always_comb
    begin
        data_next = in_data;
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
            data_next = dabble_step(data_next);
        end
    end

    // Stage register, held while the pipeline is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: sv/itda_serializer.sv
// Character serializer: sign, then digits without leading zeros, one per cycle.
module itda_serializer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  itda_pkg::itda_conv_t         in_data,
    output logic                         ready,
    output logic                         strobe,
    output logic [itda_pkg::CHAR_W-1:0]  character,
    output logic                         last
);
    import itda_pkg::*;

    logic                               active_reg;
    logic                               active_next;
    logic                               sign_reg;
    logic                               sign_next;
    logic [POS_W-1:0]                   pos_reg;
    logic [POS_W-1:0]                   pos_next;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_reg;
    logic [POS_W-1:0]                   top_idx;
    logic                               last_w;

    // Index of the most significant nonzero digit, zero if all digits are zero
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (in_data.bcd[i] != '0)
            begin
                top_idx = POS_W'(i);
            end
        end
    end

    // Current character
    assign last_w    = active_reg && !sign_reg && (pos_reg == '0);
    assign strobe    = active_reg;
    assign last      = last_w;
    assign character = sign_reg ? ASCII_MINUS
                                : ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits_reg[pos_reg]};
    assign ready     = !active_reg || last_w;

    // Sequencing of sign and digit positions
    always_comb
    begin
        active_next = active_reg;
        sign_next   = sign_reg;
        pos_next    = pos_reg;
        if (load)
        begin
            active_next = 1'b1;
            sign_next   = in_data.neg;
            pos_next    = top_idx;
        end
        else if (active_reg)
        begin
            if (sign_reg)
            begin
                sign_next = 1'b0;
            end
            else if (last_w)
            begin
                active_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg - POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            sign_reg   <= 1'b0;
            pos_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            sign_reg   <= sign_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            digits_reg <= in_data.bcd;
        end
    end

    // Checks
    a_load_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ready)
        else $error("serializer loaded while still emitting");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && sign_reg) |-> !last)
        else $error("minus sign marked as last character");

    a_digit_after_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && sign_reg) |=> (strobe && !sign_reg))
        else $error("no digit follows the minus sign");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last && !load) |=> !strobe)
        else $error("strobe after last character without a new transfer");

endmodule

FILE: sv/int_to_decimal_ascii_unit.sv
// Top level: sign/magnitude stage, BCD conversion pipeline and character serializer.
// Path to the ports: the magnitude register loads on the start transfer edge, then come 4
// conversion stages of 8 bits each and the serializer, which puts out the first character.
// Throughput: one character per cycle from the serializer, and a number takes 1 to 11
// characters; busy holds new transfers off while the last stage waits on the serializer.
// Reset clears all valid bits and the serializer; the receiver cannot stall.
module int_to_decimal_ascii_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [31:0]           value,
    output logic                         strobe,
    output logic [itda_pkg::CHAR_W-1:0]  character,
    output logic                         last
);
    import itda_pkg::*;

    logic                  s0_valid_reg;
    itda_conv_t            s0_data_reg;
    itda_conv_t            s0_data_next;
    logic [NUM_STAGES:0]   stg_valid;
    itda_conv_t            stg_data [NUM_STAGES+1];
    logic                  advance;
    logic                  ser_ready;
    logic                  ser_load;

    // Whole pipeline moves unless the last stage holds an item the serializer can't take
    assign advance  = !(stg_valid[NUM_STAGES] && !ser_ready);
    assign busy     = !advance;
    assign ser_load = stg_valid[NUM_STAGES] && advance;

    // Sign and magnitude
    always_comb
    begin
        s0_data_next.neg = value[VALUE_W-1];
        s0_data_next.bin = value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value))
                                            : VALUE_W'(value);
        s0_data_next.bcd = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_data_reg <= s0_data_next;
        end
    end

    assign stg_valid[0] = s0_valid_reg;
    assign stg_data[0]  = s0_data_reg;

    // Conversion stages
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        itda_dabble_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (stg_valid[g]),
            .in_data   (stg_data[g]),
            .out_valid (stg_valid[g+1]),
            .out_data  (stg_data[g+1])
        );
    end

    // Output characters
    itda_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ser_load),
        .in_data   (stg_data[NUM_STAGES]),
        .ready     (ser_ready),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

endmodule

FILE: dv/tb_int_to_decimal_ascii_unit.sv
// Testbench for the integer to decimal ASCII unit: self-checking stimulus and character scoreboard.
module tb_int_to_decimal_ascii_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import itda_pkg::*;

    localparam int          STALL_LIMIT  = 1000;
    localparam int          TAIL_CYCLES  = 20;
    localparam logic [31:0] DEC_BASE     = 32'd10;
    localparam int          RANDOM_ITEMS = 280;

    // One expected output character
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } char_rec_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] value;
    logic               strobe;
    logic [CHAR_W-1:0]  character;
    logic               last;

    char_rec_t pending_chars [$];
    char_rec_t head_char;
    int        fail_count    = 0;
    int        values_taken  = 0;
    int        neg_taken     = 0;
    int        zero_taken    = 0;
    int        chars_checked = 0;
    int        stall_cycles  = 0;

    int_to_decimal_ascii_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Expected text of one value: optional minus, then digits most significant first
    function automatic void predict_decimal_text(input logic [31:0] v);
        logic [31:0]       mag;
        logic [3:0]        digs [10];
        logic [CHAR_W-1:0] text [$];
        int                nd;
        mag = v[31] ? (32'd0 - v) : v;
        nd  = 0;
        do
        begin
            digs[nd] = 4'(mag % DEC_BASE);
            mag      = mag / DEC_BASE;
            nd++;
        end
        while (mag != 0 && nd < 10);
        if (v[31])
            text.push_back(ASCII_MINUS);
        for (int k = nd - 1; k >= 0; k--)
            text.push_back(ASCII_ZERO + CHAR_W'(digs[k]));
        foreach (text[i])
            pending_chars.push_back('{code: text[i], last: (i == text.size() - 1)});
    endfunction

    // Random value: full range, a chosen digit count, or near a power of ten
    function automatic logic [31:0] pick_value();
        logic [31:0] pow10 [11];
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mag;
        int          nd;
        logic        neg;
        pow10[0] = 32'd1;
        for (int i = 1; i < 10; i++)
            pow10[i] = pow10[i-1] * DEC_BASE;
        neg = 1'($urandom_range(1, 0));
        case ($urandom_range(3, 0))
            0: return $urandom;
            1, 2:
            begin
                nd  = $urandom_range(10, 1);
                lo  = (nd == 1) ? 32'd0 : pow10[nd-1];
                hi  = (nd == 10) ? (neg ? 32'h8000_0000 : 32'h7fff_ffff) : pow10[nd] - 1;
                mag = $urandom_range(hi, lo);
            end
            default:
            begin
                nd  = $urandom_range(9, 0);
                mag = pow10[nd] + 32'($urandom_range(2, 0)) - 32'd1;
            end
        endcase
        return neg ? (32'd0 - mag) : mag;
    endfunction

    // Present one value and hold it until the transfer; start stays high afterwards
    task automatic send_value(input logic [31:0] v);
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Sender gap with noise on the data port, its length given by n
    task automatic hold_off(input int n);
        start <= 1'b0;
        value <= $urandom;
        repeat (n) @(posedge clk);
    endtask

    // Idle the sender until every expected character has come out
    task automatic wait_for_drain();
        hold_off(1);
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    // Extremes, single digits, digit counts from one to four, nine and ten, sign edges and the most negative value
    task automatic test_directed_values();
        logic [31:0] corner [$];
        corner = '{32'd0, 32'd1, -32'sd1, 32'd5, -32'sd7, 32'd9, 32'd10, -32'sd10,
                   32'd99, -32'sd100, 32'd1000, 32'd123456789, -32'sd987654321,
                   32'd999999999, 32'd1000000000, -32'sd1000000000, 32'h7fff_ffff,
                   32'h8000_0001, 32'h8000_0000, 32'h8000_0002};
        foreach (corner[i])
            send_value(corner[i]);
        wait_for_drain();
    endtask

    // Six values and a full drain, then three values with sender gaps and a second drain
    task automatic test_drain_pause();
        repeat (6) send_value(pick_value());
        wait_for_drain();
        repeat (3)
        begin
            send_value(pick_value());
            hold_off($urandom_range(9, 1));
        end
        wait_for_drain();
    endtask

    // Continuous start with no sender gaps
    task automatic test_back_to_back();
        repeat (40) send_value(pick_value());
        hold_off(1);
    endtask

    // Bursts of random length separated by random gaps
    task automatic test_random_stream(input int n);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(12, 1);
            for (int i = 0; i < burst && sent < n; i++)
            begin
                send_value(pick_value());
                sent++;
            end
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(16, 1);
            if (gap > 0)
                hold_off(gap);
        end
        hold_off(1);
    endtask

    // Scoreboard: check output characters first, then record this edge's input transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
            begin
                if (pending_chars.size() == 0)
                begin
                    $error("unexpected character %0d (last %0b) with nothing pending",
                           character, last);
                    fail_count++;
                end
                else
                begin
                    head_char = pending_chars.pop_front();
                    if (character !== head_char.code)
                    begin
                        $error("character mismatch: expected %0d, got %0d",
                               head_char.code, character);
                        fail_count++;
                    end
                    if (last !== head_char.last)
                    begin
                        $error("last mismatch: expected %0b, got %0b", head_char.last, last);
                        fail_count++;
                    end
                    chars_checked++;
                end
            end
            if (start && !busy)
            begin
                predict_decimal_text(value);
                values_taken++;
                if (value[31])
                    neg_taken++;
                if (value == 0)
                    zero_taken++;
            end
        end
    end

    // Watchdog: cycles with neither an input nor an output transfer
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_values();
        test_drain_pause();
        test_back_to_back();
        test_random_stream(RANDOM_ITEMS);

        // Let the last texts finish, then watch for stray characters
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_chars.size() != 0)
        begin
            $error("%0d characters never arrived", pending_chars.size());
            fail_count++;
        end

        $display("Converted %0d values (%0d negative, %0d zero) into %0d checked characters.",
                 values_taken, neg_taken, zero_taken, chars_checked);
        $display("Covered range extremes, back-to-back starts, random sender gaps, full drains.");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
